>>> sv/mth_pkg.sv
// Shared types, constants and SHA-1 round helpers for the Merkle tree hasher.
package mth_pkg;

    localparam int LEAF_BYTES_DEF = 1024;
    localparam int MAX_LEVELS_DEF = 32;
    localparam int HASH_W         = 160;
    localparam int MERGE_BYTES    = 40;
    localparam int LEN_W          = 44;
    localparam int ROUNDS         = 80;

    localparam logic [159:0] SHA_IV =
        160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;

    localparam logic [7:0] PREFIX_LEAF = 8'h00;
    localparam logic [7:0] PREFIX_NODE = 8'h01;
    localparam logic [7:0] PAD_MARK    = 8'h80;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_TAKE,
        OP_APP_IN,
        OP_APP_PRE0,
        OP_APP_PRE1,
        OP_APP_SRC,
        OP_APP_PAD,
        OP_CLOAD,
        OP_ROUND,
        OP_CADD,
        OP_HASH_DONE,
        OP_RD,
        OP_LVL_RST,
        OP_LVL_INC,
        OP_SET_SRC,
        OP_WRITE,
        OP_TAKE_ROOT,
        OP_FILE_RST,
        OP_OUT_INC
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BYTE,
        S_MSG,
        S_PAD,
        S_CLOAD,
        S_ROUND,
        S_CADD,
        S_PUSH_RD,
        S_PUSH_CHK,
        S_PUSH_NXT,
        S_FOLD_RD,
        S_FOLD_CHK,
        S_FOLD_NXT,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        M_LEAF,
        M_PUSH,
        M_FOLD
    } t_mode;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic nb_zero;
        logic eof;
        logic leaf_full;
        logic open;
        logic src_done;
        logic pad_done;
        logic blk_last;
        logic rnd_last;
        logic lvl_valid;
        logic lvl_top;
        logic have;
        logic out_last;
    } t_sts;

    function automatic logic [31:0] sha1_f(input logic [6:0] t, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        if (t < 7'd20) begin
            f = (b & c) | (~b & d);
        end else if (t < 7'd40) begin
            f = b ^ c ^ d;
        end else if (t < 7'd60) begin
            f = (b & c) | (b & d) | (c & d);
        end else begin
            f = b ^ c ^ d;
        end
        return f;
    endfunction

    function automatic logic [31:0] sha1_k(input logic [6:0] t);
        logic [31:0] k;
        if (t < 7'd20) begin
            k = 32'h5A827999;
        end else if (t < 7'd40) begin
            k = 32'h6ED9EBA1;
        end else if (t < 7'd60) begin
            k = 32'h8F1BBCDC;
        end else begin
            k = 32'hCA62C1D6;
        end
        return k;
    endfunction

endpackage

>>> sv/mth_datapath.sv
// Datapath: byte packer, SHA-1 round engine, padding, level store and result fields.
module mth_datapath #(
    parameter int LEAF_BYTES = mth_pkg::LEAF_BYTES_DEF,
    parameter int MAX_LEVELS = mth_pkg::MAX_LEVELS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  mth_pkg::t_cmd             i_cmd,
    output mth_pkg::t_sts             o_sts,
    input  logic [63:0]               i_data_word,
    input  logic [3:0]                i_valid_bytes,
    input  logic                      i_end_of_file,
    output logic [63:0]               o_hash_word,
    output logic [1:0]                o_word_index,
    output logic [mth_pkg::LEN_W-1:0] o_file_length,
    output logic                      o_empty_file,
    output logic                      o_last
);

    localparam int LCW = $clog2(LEAF_BYTES + 1);
    localparam int MLW = $clog2(LEAF_BYTES + 2);
    localparam int LVW = $clog2(MAX_LEVELS);
    localparam logic [LCW-1:0] LEAF_FULL = LCW'(LEAF_BYTES);
    localparam logic [LVW-1:0] LVL_TOP   = LVW'(MAX_LEVELS - 1);
    localparam logic [mth_pkg::LEN_W-1:0] LEN_MAX = '1;

    logic [159:0]                r_mem [MAX_LEVELS];
    logic [MAX_LEVELS-1:0]       r_valid;
    logic [159:0]                r_rdata;
    logic [LVW-1:0]              r_lvl;
    logic                        r_have;
    logic [63:0]                 r_word;
    logic [3:0]                  r_nb;
    logic                        r_eof;
    logic [511:0]                r_blk;
    logic [5:0]                  r_bcnt;
    logic [LCW-1:0]              r_leaf_cnt;
    logic [MLW-1:0]              r_mlen;
    logic                        r_open;
    logic [1:0]                  r_phase;
    logic [3:0]                  r_lcnt;
    logic [63:0]                 r_lenw;
    logic [319:0]                r_src;
    logic [5:0]                  r_scnt;
    logic [6:0]                  r_rnd;
    logic [159:0]                r_dig;
    logic [31:0]                 r_a, r_b, r_c, r_d, r_e;
    logic [159:0]                r_h;
    logic [mth_pkg::LEN_W-1:0]   r_total;
    logic [1:0]                  r_oidx;

    logic [63:0]  len_bits;
    logic [7:0]   pad_byte;
    logic [7:0]   app_byte;
    logic         app_en;
    logic [31:0]  w_new;
    logic [31:0]  tmp;

    assign len_bits = {{(64 - MLW - 3){1'b0}}, r_mlen, 3'b000};
    assign w_new = {r_blk[511-13*32 -: 32] ^ r_blk[511-8*32 -: 32] ^ r_blk[511-2*32 -: 32]
                    ^ r_blk[511 -: 32]} << 1
                 | {31'd0, (r_blk[511-13*32] ^ r_blk[511-8*32] ^ r_blk[511-2*32] ^ r_blk[511])};
    assign tmp = {r_a[26:0], r_a[31:27]} + mth_pkg::sha1_f(r_rnd, r_b, r_c, r_d) + r_e
               + mth_pkg::sha1_k(r_rnd) + r_blk[511 -: 32];

    always_comb begin
        if (r_phase == 2'd0) begin
            pad_byte = mth_pkg::PAD_MARK;
        end else if (r_phase == 2'd1) begin
            pad_byte = (r_bcnt == 6'd56) ? len_bits[63:56] : 8'h00;
        end else begin
            pad_byte = r_lenw[63:56];
        end
    end

    always_comb begin
        app_en   = 1'b1;
        app_byte = 8'h00;
        case (i_cmd.op)
            mth_pkg::OP_APP_IN:   app_byte = r_word[63:56];
            mth_pkg::OP_APP_PRE0: app_byte = mth_pkg::PREFIX_LEAF;
            mth_pkg::OP_APP_PRE1: app_byte = mth_pkg::PREFIX_NODE;
            mth_pkg::OP_APP_SRC:  app_byte = r_src[319:312];
            mth_pkg::OP_APP_PAD:  app_byte = pad_byte;
            default:              app_en   = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (app_en) begin
            r_blk  <= {r_blk[503:0], app_byte};
        end else if (i_cmd.op == mth_pkg::OP_ROUND) begin
            r_blk  <= {r_blk[479:0], w_new};
        end
        if (i_cmd.op == mth_pkg::OP_TAKE) begin
            r_word <= i_data_word;
            r_nb   <= (i_valid_bytes > 4'd8) ? 4'd8 : i_valid_bytes;
            r_eof  <= i_end_of_file;
        end else if (i_cmd.op == mth_pkg::OP_APP_IN) begin
            r_word <= {r_word[55:0], 8'h00};
            r_nb   <= r_nb - 4'd1;
        end
        if (i_cmd.op == mth_pkg::OP_APP_PAD && r_phase == 2'd1 && r_bcnt == 6'd56) begin
            r_lenw <= {len_bits[55:0], 8'h00};
        end else if (i_cmd.op == mth_pkg::OP_APP_PAD && r_phase == 2'd2) begin
            r_lenw <= {r_lenw[55:0], 8'h00};
        end
        case (i_cmd.op)
            mth_pkg::OP_APP_SRC:   r_src <= {r_src[311:0], 8'h00};
            mth_pkg::OP_SET_SRC:   r_src <= {r_rdata, r_h};
            default:               r_src <= r_src;
        endcase
        case (i_cmd.op)
            mth_pkg::OP_CLOAD: begin
                r_a <= r_dig[159:128];
                r_b <= r_dig[127:96];
                r_c <= r_dig[95:64];
                r_d <= r_dig[63:32];
                r_e <= r_dig[31:0];
            end
            mth_pkg::OP_ROUND: begin
                r_a <= tmp;
                r_b <= r_a;
                r_c <= {r_b[1:0], r_b[31:2]};
                r_d <= r_c;
                r_e <= r_d;
            end
            default: begin
                r_a <= r_a;
            end
        endcase
        case (i_cmd.op)
            mth_pkg::OP_HASH_DONE: r_h <= r_dig;
            mth_pkg::OP_TAKE_ROOT: r_h <= r_rdata;
            default:               r_h <= r_h;
        endcase
        if (i_cmd.op == mth_pkg::OP_RD) begin
            r_rdata <= r_mem[r_lvl];
        end
        if (i_cmd.op == mth_pkg::OP_WRITE) begin
            r_mem[r_lvl] <= r_h;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_lvl      <= '0;
            r_have     <= 1'b0;
            r_bcnt     <= '0;
            r_leaf_cnt <= '0;
            r_mlen     <= '0;
            r_open     <= 1'b0;
            r_phase    <= 2'd0;
            r_lcnt     <= '0;
            r_scnt     <= '0;
            r_rnd      <= '0;
            r_dig      <= mth_pkg::SHA_IV;
            r_total    <= '0;
            r_oidx     <= '0;
        end else begin
            if (app_en) begin
                r_bcnt <= r_bcnt + 6'd1;
            end
            case (i_cmd.op)
                mth_pkg::OP_APP_IN: begin
                    r_leaf_cnt <= r_leaf_cnt + LCW'(1);
                    r_mlen     <= r_mlen + MLW'(1);
                    if (r_total != LEN_MAX) begin
                        r_total <= r_total + mth_pkg::LEN_W'(1);
                    end
                end
                mth_pkg::OP_APP_PRE0, mth_pkg::OP_APP_PRE1: begin
                    r_open <= 1'b1;
                    r_mlen <= r_mlen + MLW'(1);
                end
                mth_pkg::OP_APP_SRC: begin
                    r_scnt <= r_scnt + 6'd1;
                    r_mlen <= r_mlen + MLW'(1);
                end
                mth_pkg::OP_APP_PAD: begin
                    if (r_phase == 2'd0) begin
                        r_phase <= 2'd1;
                    end else if (r_phase == 2'd1) begin
                        if (r_bcnt == 6'd56) begin
                            r_phase <= 2'd2;
                            r_lcnt  <= 4'd1;
                        end
                    end else begin
                        r_lcnt <= r_lcnt + 4'd1;
                    end
                end
                mth_pkg::OP_CLOAD:  r_rnd <= '0;
                mth_pkg::OP_ROUND:  r_rnd <= r_rnd + 7'd1;
                mth_pkg::OP_CADD: begin
                    r_dig <= {r_dig[159:128] + r_a, r_dig[127:96] + r_b,
                              r_dig[95:64] + r_c, r_dig[63:32] + r_d, r_dig[31:0] + r_e};
                end
                mth_pkg::OP_HASH_DONE: begin
                    r_dig      <= mth_pkg::SHA_IV;
                    r_leaf_cnt <= '0;
                    r_mlen     <= '0;
                    r_open     <= 1'b0;
                    r_phase    <= 2'd0;
                    r_lcnt     <= '0;
                    r_scnt     <= '0;
                end
                mth_pkg::OP_LVL_RST: begin
                    r_lvl  <= '0;
                    r_have <= 1'b0;
                end
                mth_pkg::OP_LVL_INC:   r_lvl <= r_lvl + LVW'(1);
                mth_pkg::OP_SET_SRC: begin
                    r_valid[r_lvl] <= 1'b0;
                    r_scnt         <= '0;
                end
                mth_pkg::OP_WRITE:     r_valid[r_lvl] <= 1'b1;
                mth_pkg::OP_TAKE_ROOT: r_have <= 1'b1;
                mth_pkg::OP_FILE_RST: begin
                    r_valid <= '0;
                    r_have  <= 1'b0;
                    r_total <= '0;
                    r_oidx  <= '0;
                end
                mth_pkg::OP_OUT_INC:   r_oidx <= r_oidx + 2'd1;
                default: begin
                    r_rnd <= r_rnd;
                end
            endcase
        end
    end

    always_comb begin
        o_sts.nb_zero   = (r_nb == 4'd0);
        o_sts.eof       = r_eof;
        o_sts.leaf_full = (r_leaf_cnt == LEAF_FULL);
        o_sts.open      = r_open;
        o_sts.src_done  = (r_scnt == 6'(mth_pkg::MERGE_BYTES));
        o_sts.pad_done  = (r_phase == 2'd2) && (r_lcnt == 4'd8) && (r_bcnt == 6'd0);
        o_sts.blk_last  = (r_bcnt == 6'd63);
        o_sts.rnd_last  = (r_rnd == 7'(mth_pkg::ROUNDS - 1));
        o_sts.lvl_valid = r_valid[r_lvl];
        o_sts.lvl_top   = (r_lvl == LVL_TOP);
        o_sts.have      = r_have;
        o_sts.out_last  = !r_have || (r_oidx == 2'd2);
    end

    always_comb begin
        if (!r_have) begin
            o_hash_word = 64'd0;
        end else if (r_oidx == 2'd0) begin
            o_hash_word = r_h[159:96];
        end else if (r_oidx == 2'd1) begin
            o_hash_word = r_h[95:32];
        end else begin
            o_hash_word = {32'd0, r_h[31:0]};
        end
    end

    assign o_word_index  = r_oidx;
    assign o_file_length = r_total;
    assign o_empty_file  = !r_have;
    assign o_last        = o_sts.out_last;

endmodule

>>> sv/mth_ctrl.sv
// Controller: sequences byte packing, compression, padding, level pushes, fold and output.
module mth_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output mth_pkg::t_cmd o_cmd,
    input  mth_pkg::t_sts i_sts
);

    mth_pkg::t_state r_state, n_state;
    mth_pkg::t_state r_ret, n_ret;
    mth_pkg::t_mode  r_mode, n_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mth_pkg::S_IDLE;
            r_ret   <= mth_pkg::S_IDLE;
            r_mode  <= mth_pkg::M_LEAF;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_mode  <= n_mode;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_mode      = r_mode;
        o_cmd.op    = mth_pkg::OP_NOP;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            mth_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = mth_pkg::OP_TAKE;
                    n_state  = mth_pkg::S_BYTE;
                end
            end
            mth_pkg::S_BYTE: begin
                if (i_sts.open && i_sts.leaf_full) begin
                    n_mode  = mth_pkg::M_LEAF;
                    n_state = mth_pkg::S_PAD;
                end else if (i_sts.nb_zero) begin
                    if (!i_sts.eof) begin
                        n_state = mth_pkg::S_IDLE;
                    end else if (i_sts.open) begin
                        n_mode  = mth_pkg::M_LEAF;
                        n_state = mth_pkg::S_PAD;
                    end else begin
                        o_cmd.op = mth_pkg::OP_LVL_RST;
                        n_state  = mth_pkg::S_FOLD_RD;
                    end
                end else if (!i_sts.open) begin
                    o_cmd.op = mth_pkg::OP_APP_PRE0;
                end else begin
                    o_cmd.op = mth_pkg::OP_APP_IN;
                    if (i_sts.blk_last) begin
                        n_ret   = mth_pkg::S_BYTE;
                        n_state = mth_pkg::S_CLOAD;
                    end
                end
            end
            mth_pkg::S_MSG: begin
                if (!i_sts.open) begin
                    o_cmd.op = mth_pkg::OP_APP_PRE1;
                end else if (!i_sts.src_done) begin
                    o_cmd.op = mth_pkg::OP_APP_SRC;
                    if (i_sts.blk_last) begin
                        n_ret   = mth_pkg::S_MSG;
                        n_state = mth_pkg::S_CLOAD;
                    end
                end else begin
                    n_state = mth_pkg::S_PAD;
                end
            end
            mth_pkg::S_PAD: begin
                if (i_sts.pad_done) begin
                    o_cmd.op = mth_pkg::OP_HASH_DONE;
                    case (r_mode)
                        mth_pkg::M_LEAF: n_state = mth_pkg::S_PUSH_RD;
                        mth_pkg::M_PUSH: n_state = mth_pkg::S_PUSH_NXT;
                        default:         n_state = mth_pkg::S_FOLD_NXT;
                    endcase
                end else begin
                    o_cmd.op = mth_pkg::OP_APP_PAD;
                    if (i_sts.blk_last) begin
                        n_ret   = mth_pkg::S_PAD;
                        n_state = mth_pkg::S_CLOAD;
                    end
                end
            end
            mth_pkg::S_CLOAD: begin
                o_cmd.op = mth_pkg::OP_CLOAD;
                n_state  = mth_pkg::S_ROUND;
            end
            mth_pkg::S_ROUND: begin
                o_cmd.op = mth_pkg::OP_ROUND;
                if (i_sts.rnd_last) begin
                    n_state = mth_pkg::S_CADD;
                end
            end
            mth_pkg::S_CADD: begin
                o_cmd.op = mth_pkg::OP_CADD;
                n_state  = r_ret;
            end
            mth_pkg::S_PUSH_RD: begin
                o_cmd.op = (r_mode == mth_pkg::M_LEAF) ? mth_pkg::OP_LVL_RST : mth_pkg::OP_RD;
                if (r_mode == mth_pkg::M_LEAF) begin
                    n_mode = mth_pkg::M_PUSH;
                end else begin
                    n_state = mth_pkg::S_PUSH_CHK;
                end
            end
            mth_pkg::S_PUSH_CHK: begin
                if (i_sts.lvl_valid) begin
                    o_cmd.op = mth_pkg::OP_SET_SRC;
                    n_state  = mth_pkg::S_MSG;
                end else begin
                    o_cmd.op = mth_pkg::OP_WRITE;
                    n_state  = mth_pkg::S_BYTE;
                end
            end
            mth_pkg::S_PUSH_NXT: begin
                if (i_sts.lvl_top) begin
                    o_cmd.op = mth_pkg::OP_WRITE;
                    n_state  = mth_pkg::S_BYTE;
                end else begin
                    o_cmd.op = mth_pkg::OP_LVL_INC;
                    n_state  = mth_pkg::S_PUSH_RD;
                end
            end
            mth_pkg::S_FOLD_RD: begin
                o_cmd.op = mth_pkg::OP_RD;
                n_mode   = mth_pkg::M_FOLD;
                n_state  = mth_pkg::S_FOLD_CHK;
            end
            mth_pkg::S_FOLD_CHK: begin
                n_state = mth_pkg::S_FOLD_NXT;
                if (i_sts.lvl_valid) begin
                    if (i_sts.have) begin
                        o_cmd.op = mth_pkg::OP_SET_SRC;
                        n_state  = mth_pkg::S_MSG;
                    end else begin
                        o_cmd.op = mth_pkg::OP_TAKE_ROOT;
                    end
                end
            end
            mth_pkg::S_FOLD_NXT: begin
                if (i_sts.lvl_top) begin
                    n_state = mth_pkg::S_OUT;
                end else begin
                    o_cmd.op = mth_pkg::OP_LVL_INC;
                    n_state  = mth_pkg::S_FOLD_RD;
                end
            end
            mth_pkg::S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_sts.out_last) begin
                        o_cmd.op = mth_pkg::OP_FILE_RST;
                        n_mode   = mth_pkg::M_LEAF;
                        n_state  = mth_pkg::S_IDLE;
                    end else begin
                        o_cmd.op = mth_pkg::OP_OUT_INC;
                    end
                end
            end
            default: begin
                n_state = mth_pkg::S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_round_follows_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == mth_pkg::S_CLOAD |=> r_state == mth_pkg::S_ROUND)
        else $error("compression did not start after load");
    a_add_after_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mth_pkg::S_ROUND && i_sts.rnd_last) |=> r_state == mth_pkg::S_CADD)
        else $error("chaining add missed after last round");
    a_take_goes_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_state == mth_pkg::S_BYTE)
        else $error("input transfer not followed by byte packing");
    a_result_last_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && i_sts.out_last) |=> !i_sts.have)
        else $error("file state not cleared after final result");
`endif

endmodule

>>> sv/merkle_tree_sha1_hasher.sv
// Top level of the SHA-1 Merkle tree hasher: stream ports, controller and datapath.
// Input transfers are packed byte by byte, with a prefix byte when a leaf opens, and each
// 64-byte SHA-1 block is compressed by the single one-round-per-cycle SHA-1 engine.
// Each level merge hashes a prefix byte and two 20-byte hashes as one padded SHA-1 block.
// A new input transfer is accepted only once the controller is done with the previous one;
// end of file adds padding, fold and three result words (one for an empty file).
// Reset: synchronous active-low i_rst_n clears levels, counters and the chaining value.
module merkle_tree_sha1_hasher #(
    parameter int LEAF_BYTES = mth_pkg::LEAF_BYTES_DEF,
    parameter int MAX_LEVELS = mth_pkg::MAX_LEVELS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [71:0]  s_axis_tdata,  // data_word[63:0], valid_bytes[67:64], zero fill
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [111:0] m_axis_tdata,  // hash_word[63:0], file_length[107:64], zero fill
    output logic [2:0]   m_axis_tuser,  // word_index[1:0], empty_file[2]
    output logic         m_axis_tlast
);

    mth_pkg::t_cmd cmd;
    mth_pkg::t_sts sts;

    logic [63:0]               hash_word;
    logic [1:0]                word_index;
    logic [mth_pkg::LEN_W-1:0] file_length;
    logic                      empty_file;

    mth_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    mth_datapath #(
        .LEAF_BYTES (LEAF_BYTES),
        .MAX_LEVELS (MAX_LEVELS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_data_word   (s_axis_tdata[63:0]),
        .i_valid_bytes (s_axis_tdata[67:64]),
        .i_end_of_file (s_axis_tlast),
        .o_hash_word   (hash_word),
        .o_word_index  (word_index),
        .o_file_length (file_length),
        .o_empty_file  (empty_file),
        .o_last        (m_axis_tlast)
    );

    assign m_axis_tdata = {4'd0, file_length, hash_word};
    assign m_axis_tuser = {empty_file, word_index};

endmodule
